[rtl/core/arp_pkg.sv]
// types and constants for the relocation field patcher pipeline
// no dependencies; imported by arm_reloc_field_patcher_top
package arp_pkg;

  // relocation kinds
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_PCREL  = 2'd1,
    KIND_BRANCH = 2'd2,
    KIND_ROTIMM = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_ROT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  localparam int unsigned WordBits = 32;
  localparam int unsigned NumRot   = WordBits / 2;

  localparam logic [31:0] Imm24Mask  = 32'h00ff_ffff;
  localparam logic [31:0] ByteMask   = 32'h0000_00ff;
  localparam logic [31:0] HalfMask   = 32'h0000_ffff;
  localparam logic [31:0] FullMask   = 32'hffff_ffff;
  localparam logic [31:0] UpBit      = 32'h0080_0000;
  localparam logic [31:0] Imm12Field = 32'h0000_0fff;

  localparam logic [2:0] Size1 = 3'd1;
  localparam logic [2:0] Size2 = 3'd2;
  localparam logic [2:0] Size4 = 3'd4;

  // stage a: captured inputs
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [2:0]  bytes;
    logic [31:0] word;
  } stage_a_t;

  // stage b: offset difference and rotation candidates
  typedef struct packed {
    kind_t                  kind;
    logic [31:0]            value;
    logic [2:0]             bytes;
    logic [31:0]            word;
    logic [32:0]            diff;
    logic [NumRot-1:0]      match;
    logic [NumRot-1:0][7:0] rot_lo;
  } stage_b_t;

  // stage c: encoded field, insertion mask and status
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] field;
    logic [31:0] mask;
    status_t     status;
  } stage_c_t;

endpackage

[rtl/core/arm_reloc_field_patcher_top.sv]
// relocation field patcher: four-stage pipeline, top level
// depends on arp_pkg (types, kind and status codes, masks)
//
// usage
//   input channel: opcode, fix_value, data_bytes, old_word with in_valid and
//   in_stall; a transfer happens at a rising edge with in_valid high and
//   in_stall low
//   output channel: patched_word and status with out_valid and out_stall;
//   a transfer happens at a rising edge with out_valid high and out_stall low
//   pipeline: stage a captures the inputs, stage b forms value-4 and the
//     sixteen rotation checks, stage c picks the encoding, the output stage
//     merges the field into the old word
//   throughput: one transfer per cycle in both directions while the
//   receiver keeps out_stall low; each stage holds one item
//   stall: when out_stall is high the output register holds; bubbles ahead
//   of it still fill, and in_stall rises only when all four stages are full,
//   so nothing is dropped or repeated
//   reset: rst (synchronous) empties every stage; payload registers keep
//   whatever they held
module arm_reloc_field_patcher_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  fix_value,
  input  logic [2:0]          data_bytes,
  input  logic [31:0]         old_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         patched_word,
  output logic [1:0]          status
);
  import arp_pkg::*;

  stage_a_t a;
  stage_b_t b;
  stage_c_t c;
  stage_b_t b_next;
  stage_c_t c_next;
  logic     a_valid;
  logic     b_valid;
  logic     c_valid;

  logic     ready_o;
  logic     ready_c;
  logic     ready_b;
  logic     ready_a;

  // each stage moves when it is empty or the stage after it moves
  assign ready_o  = !out_valid || !out_stall;
  assign ready_c  = !c_valid || ready_o;
  assign ready_b  = !b_valid || ready_c;
  assign ready_a  = !a_valid || ready_b;
  assign in_stall = !ready_a;

  // stage b logic: offset difference without wrap, every even rotation
  always_comb begin
    logic [63:0] dbl;
    logic [31:0] rot;
    dbl          = {a.value, a.value};
    b_next.kind  = a.kind;
    b_next.value = a.value;
    b_next.bytes = a.bytes;
    b_next.word  = a.word;
    b_next.diff  = {a.value[31], a.value} - 33'd4;
    for (int j = 0; j < NumRot; j++) begin
      rot              = dbl[63-2*j -: 32];
      b_next.match[j]  = (rot[31:8] == 24'd0);
      b_next.rot_lo[j] = rot[7:0];
    end
  end

  // stage c logic: encode the field for each kind
  always_comb begin
    logic [32:0] mag;
    logic        found;
    logic [3:0]  rot_idx;
    logic [7:0]  rot_byte;
    mag      = b.diff[32] ? (~b.diff + 33'd1) : b.diff;
    found    = 1'b0;
    rot_idx  = '0;
    rot_byte = '0;
    // smallest rotation wins: scan from the top so the lowest match sticks
    for (int j = NumRot - 1; j >= 0; j--) begin
      if (b.match[j]) begin
        found    = 1'b1;
        rot_idx  = 4'(j);
        rot_byte = b.rot_lo[j];
      end
    end
    c_next.word   = b.word;
    c_next.field  = '0;
    c_next.mask   = '0;
    c_next.status = ST_OK;
    case (b.kind)
      KIND_DATA: begin
        c_next.field = b.value;
        case (b.bytes)
          Size4:   c_next.mask = FullMask;
          Size2:   c_next.mask = HalfMask;
          Size1:   c_next.mask = ByteMask;
          default: c_next.mask = '0;  // other sizes leave the word alone
        endcase
      end
      KIND_PCREL: begin
        if (mag[32:12] != 21'd0) begin
          // magnitude 4096 or more: word unchanged
          c_next.status = ST_RANGE;
        end else begin
          c_next.field = (b.diff[32] ? 32'd0 : UpBit) | {20'd0, mag[11:0]};
          c_next.mask  = UpBit | Imm12Field;
        end
      end
      KIND_BRANCH: begin
        c_next.field = {8'd0, b.diff[25:2]};
        c_next.mask  = Imm24Mask;
      end
      KIND_ROTIMM: begin
        c_next.mask = Imm12Field;
        if (found) begin
          c_next.field = {20'd0, rot_idx, rot_byte};
        end else begin
          // not encodable: clear the immediate field
          c_next.status = ST_NO_ROT;
        end
      end
      default: begin
        c_next.mask = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_a) a_valid <= in_valid;
      if (ready_b) b_valid <= a_valid;
      if (ready_c) c_valid <= b_valid;
      if (ready_o) out_valid <= c_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ready_a) begin
      a.kind  <= kind_t'(opcode);
      a.value <= fix_value;
      a.bytes <= data_bytes;
      a.word  <= old_word;
    end
    if (ready_b) b <= b_next;
    if (ready_c) c <= c_next;
    if (ready_o && c_valid) begin
      patched_word <= (c.word & ~c.mask) | (c.field & c.mask);
      status       <= c.status;
    end
  end

  // the input side stalls only with every stage occupied
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && b_valid && c_valid && out_valid))
    else $error("input stalled with an empty pipeline stage");

  // an out-of-range offset never touches the word
  range_leaves_word: assert property (@(posedge clk) disable iff (rst)
    (c_valid && c.status == ST_RANGE) |-> (c.mask == 32'd0))
    else $error("out-of-range offset with a nonzero insertion mask");

  // a result leaving the output stage while stage c is full is refilled next cycle
  refill_on_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && c_valid) |=> out_valid)
    else $error("output stage failed to take the waiting item");

  // status is always one of the defined codes
  status_defined: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NO_ROT || status == ST_RANGE))
    else $error("undefined status code at the output");

endmodule

[sim/tb_arm_reloc_field_patcher_top.sv]
// self-checking testbench for arm_reloc_field_patcher_top: directed and random fixups
// depends on arp_pkg and the patcher rtl; a built-in predictor checks every result
module tb_arm_reloc_field_patcher_top;
  import arp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one pending fixup; hold_for_drain makes the sender wait until nothing is in flight
  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic [2:0]  bytes;
    logic [31:0] word;
    bit          hold_for_drain;
  } fixup_t;

  // expected outcome of one fixup
  typedef struct {
    logic [31:0] word;
    status_t     status;
  } patch_t;

  localparam int HoldCycles = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [31:0] fix_value = '0;
  logic [2:0]  data_bytes = '0;
  logic [31:0] old_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] patched_word;
  logic [1:0]  status;

  fixup_t pending_fixups[$];
  patch_t expected_patches[$];

  // idle mix, written only at rising edges by the sequencer
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  logic   in_taken = 1'b0;
  fixup_t drive_item;

  int fixups_in = 0;
  int results_checked = 0;
  int mismatches = 0;
  int drain_pauses = 0;
  int status_seen[3] = '{0, 0, 0};

  arm_reloc_field_patcher_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .fix_value    (fix_value),
    .data_bytes   (data_bytes),
    .old_word     (old_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .patched_word (patched_word),
    .status       (status)
  );

  always #1 clk = ~clk;

  // predictor: the word after the fixup and its status
  function automatic patch_t encode_fixup(kind_t kind, logic [31:0] value,
                                          logic [2:0] bytes, logic [31:0] word);
    patch_t      res;
    longint      offset;
    longint      mag;
    logic [31:0] field;
    logic [63:0] pair;
    bit          found;
    res.word = word;
    res.status = ST_OK;
    case (kind)
      KIND_DATA: begin
        // sizes other than 1, 2 and 4 leave the word alone
        if (bytes == Size4) begin
          res.word = value;
        end else if (bytes == Size2) begin
          res.word = (word & ~HalfMask) | (value & HalfMask);
        end else if (bytes == Size1) begin
          res.word = (word & ~ByteMask) | (value & ByteMask);
        end
      end
      KIND_PCREL: begin
        // value-4 taken at full precision, no 32-bit wrap
        offset = longint'($signed(value)) - 64'sd4;
        mag = (offset < 0) ? -offset : offset;
        if (mag > longint'(Imm12Field)) begin
          res.status = ST_RANGE;
        end else begin
          field = 32'(mag) | ((offset >= 0) ? UpBit : 32'd0);
          res.word = (word & ~(UpBit | Imm12Field)) | field;
        end
      end
      KIND_BRANCH: begin
        field = (value - 32'd4) >> 2;
        res.word = (word & ~Imm24Mask) | (field & Imm24Mask);
      end
      default: begin
        // smallest even left rotation that fits in a byte
        field = '0;
        found = 1'b0;
        for (int k = 0; k < NumRot; k++) begin
          pair = {value, value} << (2 * k);
          if (!found && pair[63:32] <= ByteMask) begin
            field = {20'd0, 4'(k), pair[39:32]};
            found = 1'b1;
          end
        end
        if (!found) begin
          res.status = ST_NO_ROT;
        end
        res.word = (word & ~Imm12Field) | field;
      end
    endcase
    return res;
  endfunction

  task automatic queue_fixup(kind_t kind, logic [31:0] value, logic [2:0] bytes,
                             logic [31:0] word);
    fixup_t f;
    f.kind = kind;
    f.value = value;
    f.bytes = bytes;
    f.word = word;
    f.hold_for_drain = 1'b0;
    pending_fixups.push_back(f);
  endtask

  // one phase of random fixups under a given idle mix; returns once all are handed out
  task automatic run_phase(int idle_pct, int stall_pct, int count, bit long_hold);
    int          first;
    logic [31:0] v;
    logic [31:0] b;
    logic [31:0] mag;
    logic [63:0] pair;
    logic [2:0]  nbytes;
    logic [31:0] w;
    first = pending_fixups.size();
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0, 1: v = $urandom;
        // offsets near zero, inside and outside the 12-bit range
        2: v = 32'd4 + 32'($urandom_range(9000)) - 32'd4500;
        // right at the 12-bit range edge on both sides
        3: begin
          mag = 32'd4094 + 32'($urandom_range(3));
          v = $urandom_range(1) ? 32'd4 + mag : 32'd4 - mag;
        end
        // a byte rotated by an even amount always encodes
        4: begin
          b = 32'($urandom_range(255));
          pair = {b, b} >> (2 * $urandom_range(15));
          v = pair[31:0];
        end
        // odd rotations and two-byte patterns mostly do not
        5: begin
          b = 32'($urandom_range(1023));
          pair = {b, b} >> $urandom_range(31);
          v = pair[31:0];
        end
        6: begin
          case ($urandom_range(5))
            0: v = 32'h0000_0000;
            1: v = 32'hffff_ffff;
            2: v = 32'h8000_0000;
            3: v = 32'h7fff_ffff;
            4: v = 32'd4;
            default: v = 32'd3;
          endcase
        end
        default: v = $urandom >> $urandom_range(31);
      endcase
      case ($urandom_range(9))
        0, 1, 2: nbytes = Size1;
        3, 4: nbytes = Size2;
        5, 6: nbytes = Size4;
        default: nbytes = 3'($urandom_range(7));
      endcase
      case ($urandom_range(9))
        0: w = 32'h0000_0000;
        1: w = 32'hffff_ffff;
        default: w = $urandom;
      endcase
      queue_fixup(kind_t'($urandom_range(3)), v, nbytes, w);
    end
    // sender waits at the head of the phase until every result is back
    pending_fixups[first].hold_for_drain = 1'b1;
    if (long_hold) begin
      holds_asked++;
    end
    while (pending_fixups.size() != 0) @(posedge clk);
  endtask

  // sender: new transfer offered at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_fixups.size() != 0 && pending_fixups[0].hold_for_drain &&
          expected_patches.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_fixups.size() != 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        drive_item = pending_fixups.pop_front();
        if (drive_item.hold_for_drain) begin
          drain_pauses++;
        end
        opcode     <= drive_item.kind;
        fix_value  <= drive_item.value;
        data_bytes <= drive_item.bytes;
        old_word   <= drive_item.word;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random, or a long hold-off counted here while the sender keeps going
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : monitor
    patch_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_patches.push_back(encode_fixup(kind_t'(opcode), fix_value, data_bytes,
                                                old_word));
        fixups_in++;
      end
      if (out_valid && !out_stall) begin
        if (expected_patches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result with nothing expected: word %h status %0d",
                     $realtime, patched_word, status);
          end
        end else begin
          want = expected_patches.pop_front();
          results_checked++;
          if (patched_word !== want.word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] patched_word mismatch: expected %h got %h",
                       $realtime, want.word, patched_word);
            end
          end
          if (status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] status mismatch: expected %0d got %0d",
                       $realtime, want.status, status);
            end
          end
          if (int'(want.status) < 3) begin
            status_seen[int'(want.status)]++;
          end
        end
      end
    end
  end

  // sequencer
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain data: sizes 4, 2 and 1, and sizes 0, 3 and 7 that leave the word alone
    queue_fixup(KIND_DATA, 32'hffff_ffff, Size4, 32'h0000_0000);
    queue_fixup(KIND_DATA, 32'h0000_0000, Size2, 32'hffff_ffff);
    queue_fixup(KIND_DATA, 32'hffff_ffff, Size1, 32'h0000_0000);
    queue_fixup(KIND_DATA, 32'h1234_5678, 3'd0, 32'hdead_beef);
    queue_fixup(KIND_DATA, 32'h1234_5678, 3'd3, 32'hdead_beef);
    queue_fixup(KIND_DATA, 32'h1234_5678, 3'd7, 32'hdead_beef);
    // pc-relative imm12: zero offset, both range edges, extremes without wrap
    queue_fixup(KIND_PCREL, 32'd4, Size4, 32'hffff_ffff);
    queue_fixup(KIND_PCREL, 32'd0, Size4, 32'hffff_ffff);
    queue_fixup(KIND_PCREL, 32'd4099, Size4, 32'h0000_0000);
    queue_fixup(KIND_PCREL, 32'd4100, Size4, 32'h0000_0000);
    queue_fixup(KIND_PCREL, -32'sd4091, Size4, 32'ha5a5_a5a5);
    queue_fixup(KIND_PCREL, -32'sd4092, Size4, 32'ha5a5_a5a5);
    queue_fixup(KIND_PCREL, 32'h8000_0000, Size4, 32'h5a5a_5a5a);
    queue_fixup(KIND_PCREL, 32'h7fff_ffff, Size4, 32'h5a5a_5a5a);
    // branch imm24: no range check, negative offsets keep their sign bits
    queue_fixup(KIND_BRANCH, 32'd4, Size4, 32'hffff_ffff);
    queue_fixup(KIND_BRANCH, 32'd0, Size4, 32'h0000_0000);
    queue_fixup(KIND_BRANCH, 32'h8000_0000, Size4, 32'hffff_ffff);
    queue_fixup(KIND_BRANCH, 32'h7fff_ffff, Size4, 32'h0000_0000);
    // rotated immediate: plain byte, rotated forms and values that cannot encode
    queue_fixup(KIND_ROTIMM, 32'h0000_0000, Size4, 32'hffff_ffff);
    queue_fixup(KIND_ROTIMM, 32'h0000_00ff, Size4, 32'h0000_0000);
    queue_fixup(KIND_ROTIMM, 32'h0000_0100, Size4, 32'h0000_0000);
    queue_fixup(KIND_ROTIMM, 32'hff00_0000, Size4, 32'hffff_ffff);
    queue_fixup(KIND_ROTIMM, 32'hf000_000f, Size4, 32'h1234_5678);
    queue_fixup(KIND_ROTIMM, 32'h0000_0101, Size4, 32'hffff_ffff);
    queue_fixup(KIND_ROTIMM, 32'hffff_ffff, Size4, 32'hffff_ffff);

    // no idling, with one long output hold-off so the pipe backs up into in_stall
    run_phase(0, 0, 400, 1'b1);
    run_phase(58, 0, 400, 1'b0);
    run_phase(0, 58, 400, 1'b0);
    run_phase(28, 28, 400, 1'b0);

    // all fixups handed out; wait for the last transfer and its result
    do @(posedge clk); while (pending_fixups.size() != 0 || in_valid);
    do @(negedge clk); while (expected_patches.size() != 0);
    repeat (10) @(posedge clk);

    $display("covered %0d fixups over four idle mixes, %0d output hold-off(s), %0d drain pauses",
             fixups_in, holds_done, drain_pauses);
    $display("checked %0d results: %0d ok, %0d not encodable, %0d out of range",
             results_checked, status_seen[0], status_seen[1], status_seen[2]);
    if (mismatches == 0 && expected_patches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/core/arp_pkg.sv
rtl/core/arm_reloc_field_patcher_top.sv
sim/tb_arm_reloc_field_patcher_top.sv
